>>> hdl/llc_replacement_ship_dip_deadblock_macros.svh
// ----------------------------------------------------------------------------
// LLC replacement assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LLC_REPLACEMENT_SHIP_DIP_DEADBLOCK_MACROS_SVH
`define LLC_REPLACEMENT_SHIP_DIP_DEADBLOCK_MACROS_SVH

// consequent holds in the same cycle
`define LRSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define LRSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lrsd_pkg.sv
// ----------------------------------------------------------------------------
// LLC replacement package
// Shared types and fixed constants of the replacement policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsd_pkg;

    localparam int SET_IN_W    = 11;
    localparam int WAY_IN_W    = 4;
    localparam int PC_W        = 64;
    localparam int TYPE_W      = 2;
    localparam int PERIOD_W    = 24;
    localparam int THR_W       = 2;
    localparam int DEAD_W      = 2;
    localparam int SIGC_W      = 2;
    localparam int LFSR_W      = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int PC_FOLD     = 16;
    localparam int BIP_BITS    = 5;

    localparam logic              CMD_QUERY          = 1'b0;
    localparam logic              CMD_UPDATE         = 1'b1;
    localparam logic [TYPE_W-1:0] ACCESS_LOAD        = 2'd0;
    localparam logic              REG_DECAY_PERIOD   = 1'b0;
    localparam logic              REG_DEAD_THRESHOLD = 1'b1;

    localparam logic [PERIOD_W-1:0] DECAY_RESET = 24'd100000;
    localparam logic [THR_W-1:0]    THR_RESET   = 2'd2;
    localparam logic [LFSR_W-1:0]   LFSR_SEED   = 16'd1;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS   = 16'hB400;
    localparam logic [SIGC_W-1:0]   SIG_RESET   = 2'd1;
    localparam logic [SIGC_W-1:0]   SIG_MAX     = 2'd3;
    localparam logic [DEAD_W-1:0]   DEAD_MAX    = 2'd3;

    typedef struct packed {
        logic init_step;
        logic capture;
        logic sweep_step;
        logic read;
        logic modify;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic need_decay;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/llc_replacement_ship_dip_deadblock.sv
// ----------------------------------------------------------------------------
// LLC replacement policy top level
// LRU stack with signature and dead-block insertion and DIP set dueling.
// ----------------------------------------------------------------------------
// After reset the block clears all NUM_SETS set rows and SIGNATURE_ENTRIES
// signature counters, one entry a cycle, and takes no request meanwhile;
// configuration writes are accepted at any time. Each request then steps
// through the accepting cycle, a read of the set row and signature counter,
// a modify, a victim search with, for updates, the write-back, and a load of
// the output registers, which raises out_valid; the load waits while the
// previous result is still held. Every decay_period updates, an update first
// runs a decay sweep over the set memory, one row read-modify-write a cycle
// through its single write port.
`default_nettype none

module llc_replacement_ship_dip_deadblock #(
    parameter int NUM_SETS          = 2048,
    parameter int NUM_WAYS          = 16,
    parameter int SIGNATURE_ENTRIES = 8192,
    parameter int LEADER_SETS       = 32,
    parameter int SELECTOR_BITS     = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lrsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lrsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lrsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [lrsd_pkg::SET_IN_W-1:0]     set_index,
    input  wire logic [lrsd_pkg::WAY_IN_W-1:0]     way_index,
    input  wire logic [lrsd_pkg::PC_W-1:0]         pc,
    input  wire logic                              hit,
    input  wire logic [lrsd_pkg::TYPE_W-1:0]       access_type,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [lrsd_pkg::WAY_IN_W-1:0]     victim_way,
    output logic                                   update_done
);
    import lrsd_pkg::*;

    logic [PERIOD_W-1:0] decay_period_reg;
    logic [THR_W-1:0]    dead_threshold_reg;
    logic                cfg_write;
    ctrl_cmd_t           cmd;
    dp_status_t          status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_period_reg   <= DECAY_RESET;
            dead_threshold_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_DECAY_PERIOD:   decay_period_reg   <= pwdata[PERIOD_W-1:0];
                REG_DEAD_THRESHOLD: dead_threshold_reg <= pwdata[THR_W-1:0];
                default:            decay_period_reg   <= decay_period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DECAY_PERIOD:   prdata = APB_DATA_W'(decay_period_reg);
            REG_DEAD_THRESHOLD: prdata = APB_DATA_W'(dead_threshold_reg);
            default:            prdata = '0;
        endcase
    end

    lrsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    lrsd_dpath #(
        .NUM_SETS          (NUM_SETS),
        .NUM_WAYS          (NUM_WAYS),
        .SIGNATURE_ENTRIES (SIGNATURE_ENTRIES),
        .LEADER_SETS       (LEADER_SETS),
        .SELECTOR_BITS     (SELECTOR_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .decay_period   (decay_period_reg),
        .dead_threshold (dead_threshold_reg),
        .command        (command),
        .set_index      (set_index),
        .way_index      (way_index),
        .pc             (pc),
        .hit            (hit),
        .access_type    (access_type),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .victim_way     (victim_way),
        .update_done    (update_done)
    );

endmodule

`default_nettype wire

>>> hdl/lrsd_ram.sv
// ----------------------------------------------------------------------------
// LLC replacement RAM
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lrsd_ctrl.sv
// ----------------------------------------------------------------------------
// LLC replacement controller
// Sequences clearing, decay sweeps and the per-request read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "llc_replacement_ship_dip_deadblock_macros.svh"

module lrsd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire lrsd_pkg::dp_status_t status,
    output lrsd_pkg::ctrl_cmd_t      cmd,
    output logic                     in_ready
);
    import lrsd_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_DECAY  = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_MODIFY = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_HOLD   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.need_decay ? ST_DECAY : ST_READ;
                end
            end
            ST_DECAY:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    `LRSD_ASSERT_NEXT(a_capture_moves_on, cmd.capture,
        state_reg == ST_DECAY || state_reg == ST_READ, "capture did not start work")
    `LRSD_ASSERT_NOW(a_ready_only_idle, in_ready, !status.init_last || state_reg == ST_IDLE,
        "request taken outside idle")
    `LRSD_ASSERT_NEXT(a_finish_then_hold, cmd.finish, state_reg == ST_HOLD,
        "finish not followed by hold")

endmodule

`default_nettype wire

>>> hdl/lrsd_dpath.sv
// ----------------------------------------------------------------------------
// LLC replacement datapath
// Set metadata and signature memories, policy registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "llc_replacement_ship_dip_deadblock_macros.svh"

module lrsd_dpath #(
    parameter int NUM_SETS          = 2048,
    parameter int NUM_WAYS          = 16,
    parameter int SIGNATURE_ENTRIES = 8192,
    parameter int LEADER_SETS       = 32,
    parameter int SELECTOR_BITS     = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lrsd_pkg::ctrl_cmd_t             cmd,
    output lrsd_pkg::dp_status_t                 status,
    input  wire logic [lrsd_pkg::PERIOD_W-1:0]   decay_period,
    input  wire logic [lrsd_pkg::THR_W-1:0]      dead_threshold,
    input  wire logic                            command,
    input  wire logic [lrsd_pkg::SET_IN_W-1:0]   set_index,
    input  wire logic [lrsd_pkg::WAY_IN_W-1:0]   way_index,
    input  wire logic [lrsd_pkg::PC_W-1:0]       pc,
    input  wire logic                            hit,
    input  wire logic [lrsd_pkg::TYPE_W-1:0]     access_type,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [lrsd_pkg::WAY_IN_W-1:0]        victim_way,
    output logic                                 update_done
);
    import lrsd_pkg::*;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int SIG_W    = $clog2(SIGNATURE_ENTRIES);
    localparam int POS_BITS = NUM_WAYS * WAY_W;
    localparam int ROW_W    = NUM_WAYS * (WAY_W + DEAD_W);
    localparam int CLR_N    = (NUM_SETS > SIGNATURE_ENTRIES) ? NUM_SETS : SIGNATURE_ENTRIES;
    localparam int CLR_W    = $clog2(CLR_N);
    localparam int LEAD_N   = (LEADER_SETS < NUM_SETS) ? LEADER_SETS : NUM_SETS;
    localparam int BIP_BASE = NUM_SETS - LEAD_N;
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;

    // request registers
    logic             cmd_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [SIG_W-1:0] sig_reg;
    logic             hit_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [PC_W-1:0]  pc_mix;

    // policy state
    logic [SELECTOR_BITS-1:0] psel_reg;
    logic [SELECTOR_BITS-1:0] psel_up;
    logic [SELECTOR_BITS-1:0] psel_next;
    logic [PERIOD_W-1:0]      acc_reg;
    logic [PERIOD_W:0]        acc_inc;
    logic [LFSR_W-1:0]        lfsr_reg;
    logic [LFSR_W-1:0]        lfsr_step;

    // sweep and clearing control
    logic [CLR_W-1:0] init_cnt_reg;
    logic [SET_W-1:0] sweep_cnt_reg;
    logic             sweep_done_reg;
    logic             sweep_issue;
    logic             s1_vld_reg;
    logic [SET_W-1:0] s1_addr_reg;
    logic             init_rows;
    logic             init_sigs;

    // memories
    logic             row_we;
    logic [SET_W-1:0] row_waddr;
    logic [ROW_W-1:0] row_wdata;
    logic             row_re;
    logic [SET_W-1:0] row_raddr;
    logic [ROW_W-1:0] row_rdata;
    logic             sig_we;
    logic [SIG_W-1:0] sig_waddr;
    logic [SIGC_W-1:0] sig_wdata;
    logic [SIGC_W-1:0] sig_rdata;

    // row views
    logic [NUM_WAYS-1:0][WAY_W-1:0]  rd_pos;
    logic [NUM_WAYS-1:0][DEAD_W-1:0] rd_dead;
    logic [NUM_WAYS-1:0][WAY_W-1:0]  mod_pos;
    logic [NUM_WAYS-1:0][DEAD_W-1:0] mod_dead;
    logic [NUM_WAYS-1:0][DEAD_W-1:0] dec_dead;
    logic [NUM_WAYS-1:0][WAY_W-1:0]  init_pos;
    logic [NUM_WAYS-1:0][WAY_W-1:0]  pos_reg;
    logic [NUM_WAYS-1:0][DEAD_W-1:0] dead_reg;
    logic [NUM_WAYS-1:0][DEAD_W-1:0] fin_dead;

    // modify decision
    logic [WAY_W-1:0]  old_pos;
    logic [DEAD_W-1:0] way_dead;
    logic              mru_ldr;
    logic              bip_ldr;
    logic              forced;
    logic              bip_policy;
    logic              bip_dec;
    logic              to_mru;

    // victim tree
    logic [WAY_W-1:0] tv_val [NUM_WAYS];
    logic [WAY_W-1:0] tv_idx [NUM_WAYS];
    logic [WAY_W-1:0] vic;

    // results
    logic [WAY_IN_W-1:0] res_victim_reg;
    logic                res_done_reg;

    assign pc_mix   = pc ^ (pc >> PC_FOLD);
    assign acc_inc  = {1'b0, acc_reg} + (PERIOD_W + 1)'(1);

    assign status.need_decay = (command == CMD_UPDATE) && (acc_inc >= {1'b0, decay_period});
    assign status.init_last  = init_cnt_reg == CLR_W'(CLR_N - 1);
    assign status.sweep_last = s1_vld_reg && (s1_addr_reg == SET_W'(NUM_SETS - 1));
    assign status.out_free   = !out_valid || out_ready;

    assign init_rows   = cmd.init_step && (32'(init_cnt_reg) < NUM_SETS);
    assign init_sigs   = cmd.init_step && (32'(init_cnt_reg) < SIGNATURE_ENTRIES);
    assign sweep_issue = cmd.sweep_step && !sweep_done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            set_reg  <= SET_W'(set_index);
            way_reg  <= WAY_W'(way_index);
            sig_reg  <= pc_mix[SIG_W-1:0];
            hit_reg  <= hit;
            type_reg <= access_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg   <= '0;
            sweep_cnt_reg  <= '0;
            sweep_done_reg <= 1'b0;
            s1_vld_reg     <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            s1_vld_reg <= sweep_issue;
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + CLR_W'(1);
            end
            if (cmd.capture)
            begin
                sweep_cnt_reg  <= '0;
                sweep_done_reg <= 1'b0;
                if (command == CMD_UPDATE)
                begin
                    acc_reg <= status.need_decay ? '0 : acc_inc[PERIOD_W-1:0];
                end
            end
            else if (sweep_issue)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + SET_W'(1);
                if (sweep_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    sweep_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_issue)
        begin
            s1_addr_reg <= sweep_cnt_reg;
        end
    end

    assign rd_pos  = row_rdata[POS_BITS-1:0];
    assign rd_dead = row_rdata[ROW_W-1:POS_BITS];

    assign old_pos    = rd_pos[way_reg];
    assign way_dead   = rd_dead[way_reg];
    assign mru_ldr    = 32'(set_reg) < LEAD_N;
    assign bip_ldr    = 32'(set_reg) >= BIP_BASE;
    assign forced     = (sig_rdata == '0) || (way_dead >= dead_threshold);
    assign bip_policy = bip_ldr || (psel_reg < SEL_MID);
    assign bip_dec    = !hit_reg && !forced && !mru_ldr && bip_policy;
    assign lfsr_step  = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign to_mru     = hit_reg || (!forced && (mru_ldr || !bip_policy
                                                || lfsr_step[BIP_BITS-1:0] == '0));

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            mod_pos[w]  = rd_pos[w];
            mod_dead[w] = rd_dead[w];
            dec_dead[w] = (rd_dead[w] != '0) ? rd_dead[w] - DEAD_W'(1) : rd_dead[w];
            init_pos[w] = WAY_W'(w);
            if (to_mru && (rd_pos[w] < old_pos))
            begin
                mod_pos[w] = rd_pos[w] + WAY_W'(1);
            end
        end
        mod_dead[way_reg] = '0;
        if (to_mru)
        begin
            mod_pos[way_reg] = '0;
        end
    end

    always_comb
    begin
        psel_up   = ((mru_ldr) && (psel_reg < SEL_MAX)) ? psel_reg + SELECTOR_BITS'(1)
                                                        : psel_reg;
        psel_next = ((bip_ldr) && (psel_up != '0)) ? psel_up - SELECTOR_BITS'(1) : psel_up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psel_reg <= SEL_MID;
            lfsr_reg <= LFSR_SEED;
        end
        else if (cmd.modify && (cmd_reg == CMD_UPDATE))
        begin
            if (hit_reg && (type_reg == ACCESS_LOAD))
            begin
                psel_reg <= psel_next;
            end
            if (bip_dec)
            begin
                lfsr_reg <= lfsr_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.modify)
        begin
            pos_reg  <= (cmd_reg == CMD_UPDATE) ? mod_pos : rd_pos;
            dead_reg <= (cmd_reg == CMD_UPDATE) ? mod_dead : rd_dead;
        end
    end

    // max-position search, highest way wins ties
    always_comb
    begin
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            tv_val[k] = pos_reg[k];
            tv_idx[k] = WAY_W'(k);
        end
        for (int s = 1; s < NUM_WAYS; s = s * 2)
        begin
            for (int k = 0; k + s < NUM_WAYS; k = k + 2 * s)
            begin
                if (tv_val[k + s] >= tv_val[k])
                begin
                    tv_val[k] = tv_val[k + s];
                    tv_idx[k] = tv_idx[k + s];
                end
            end
        end
        vic = tv_idx[0];
    end

    always_comb
    begin
        fin_dead = dead_reg;
        if (!hit_reg && (dead_reg[vic] != DEAD_MAX))
        begin
            fin_dead[vic] = dead_reg[vic] + DEAD_W'(1);
        end
    end

    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = {fin_dead, pos_reg};
        if (init_rows)
        begin
            row_we    = 1'b1;
            row_waddr = init_cnt_reg[SET_W-1:0];
            row_wdata = {{(NUM_WAYS * DEAD_W){1'b0}}, init_pos};
        end
        else if (s1_vld_reg)
        begin
            row_we    = 1'b1;
            row_waddr = s1_addr_reg;
            row_wdata = {dec_dead, rd_pos};
        end
        else if (cmd.finish && (cmd_reg == CMD_UPDATE))
        begin
            row_we = 1'b1;
        end
    end

    assign row_re    = cmd.read || sweep_issue;
    assign row_raddr = cmd.read ? set_reg : sweep_cnt_reg;

    always_comb
    begin
        sig_we    = 1'b0;
        sig_waddr = sig_reg;
        sig_wdata = (sig_rdata != SIG_MAX) ? sig_rdata + SIGC_W'(1) : sig_rdata;
        if (init_sigs)
        begin
            sig_we    = 1'b1;
            sig_waddr = init_cnt_reg[SIG_W-1:0];
            sig_wdata = SIG_RESET;
        end
        else if (cmd.modify && (cmd_reg == CMD_UPDATE) && hit_reg)
        begin
            sig_we = 1'b1;
        end
    end

    lrsd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    lrsd_ram #(
        .WIDTH (SIGC_W),
        .DEPTH (SIGNATURE_ENTRIES)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .re    (cmd.read),
        .raddr (sig_reg),
        .rdata (sig_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_victim_reg <= (cmd_reg == CMD_UPDATE) ? '0 : WAY_IN_W'(vic);
            res_done_reg   <= cmd_reg;
        end
        if (cmd.load_out)
        begin
            victim_way  <= res_victim_reg;
            update_done <= res_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    `LRSD_ASSERT_NOW(a_lfsr_nonzero, 1'b1, lfsr_reg != '0, "insertion LFSR reached zero")
    `LRSD_ASSERT_NOW(a_update_writes_set, cmd.finish && (cmd_reg == CMD_UPDATE),
        row_we && (row_waddr == set_reg), "update write-back missed its set")
    `LRSD_ASSERT_NEXT(a_psel_hold, !cmd.modify, $stable(psel_reg),
        "selector moved outside modify")

endmodule

`default_nettype wire
